// File: rtl/mlt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mlt_pkg;

  localparam int NUM_LISTS_DEF = 10;
  localparam int CAPACITY_DEF  = 16;

  localparam int CMD_W    = 3;
  localparam int SLOT_W   = 4;
  localparam int VALUE_W  = 32;
  localparam int AMOUNT_W = 8;
  localparam int STATUS_W = 4;

  localparam int S_TDATA_W = ((SLOT_W + VALUE_W + AMOUNT_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((STATUS_W + VALUE_W + 7) / 8) * 8;
  localparam int M_PAD_W   = M_TDATA_W - STATUS_W - VALUE_W;

  localparam logic [CMD_W-1:0] CMD_CREATE       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND       = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE_LAST  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE_VALUE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RESIZE       = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ         = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 4'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_POS   = 4'd1;
  localparam logic [STATUS_W-1:0] ST_EXISTS    = 4'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE  = 4'd3;
  localparam logic [STATUS_W-1:0] ST_NO_MEM    = 4'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 4'd5;
  localparam logic [STATUS_W-1:0] ST_NO_LIST   = 4'd6;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 4'd7;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 4'd8;
  localparam logic [STATUS_W-1:0] ST_BAD_NEW   = 4'd9;

  typedef struct packed {
    logic load_in;
    logic single;
    logic clr_idx;
    logic inc_idx;
    logic shift_wr;
    logic emit_hit;
    logic emit_miss;
    logic emit_elem;
  } mlt_cmd_t;

  typedef struct packed {
    logic go_search;
    logic go_read;
    logic match;
    logic last_idx;
    logic out_free;
  } mlt_stat_t;

endpackage

`default_nettype wire

// File: rtl/mlt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module mlt_datapath #(
  parameter int NUM_LISTS = mlt_pkg::NUM_LISTS_DEF,
  parameter int CAPACITY  = mlt_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [mlt_pkg::CMD_W-1:0]           in_cmd,
  input  logic [mlt_pkg::SLOT_W-1:0]          in_slot,
  input  logic signed [mlt_pkg::VALUE_W-1:0]  in_value,
  input  logic signed [mlt_pkg::AMOUNT_W-1:0] in_amount,
  input  mlt_pkg::mlt_cmd_t                   ctl,
  output mlt_pkg::mlt_stat_t                  stat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mlt_pkg::STATUS_W-1:0]        out_status,
  output logic signed [mlt_pkg::VALUE_W-1:0]  out_data,
  output logic                                out_has_data,
  output logic                                out_last
);
  import mlt_pkg::*;

  localparam int LIST_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int DEPTH  = NUM_LISTS * CAPACITY;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W  = ((CNT_W + 1 > AMOUNT_W) ? CNT_W + 1 : AMOUNT_W) + 1;

  localparam logic signed [SUM_W-1:0] CAP_LIM  = SUM_W'(CAPACITY);
  localparam logic signed [SUM_W-1:0] SIZE_MIN = SUM_W'(1);

  logic [CMD_W-1:0]           cmd_q;
  logic [SLOT_W-1:0]          slot_q;
  logic signed [VALUE_W-1:0]  value_q;
  logic signed [AMOUNT_W-1:0] amount_q;

  logic             allocated [NUM_LISTS];
  logic [CNT_W-1:0] cap_arr   [NUM_LISTS];
  logic [CNT_W-1:0] fill_arr  [NUM_LISTS];

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rdata;

  logic [IDX_W-1:0]  idx_cnt;
  logic              slot_ok;
  logic              cmd_ok;
  logic [LIST_W-1:0] idx;
  logic              alloc_cur;
  logic [CNT_W-1:0]  cap_cur;
  logic [CNT_W-1:0]  fill_cur;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;
  logic              mem_we;
  logic [VALUE_W-1:0] wdata;

  logic signed [SUM_W-1:0] amt_ext;
  logic signed [SUM_W-1:0] cap_ext;
  logic signed [SUM_W-1:0] new_size;
  logic [CNT_W-1:0]        new_cnt;

  logic [STATUS_W-1:0] single_st;
  logic                single_ok;
  logic                alloc_we;
  logic                cap_we;
  logic                fill_we;
  logic [CNT_W-1:0]    cap_new;
  logic [CNT_W-1:0]    fill_new;
  logic                out_load;

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      cmd_q    <= in_cmd;
      slot_q   <= in_slot;
      value_q  <= in_value;
      amount_q <= in_amount;
    end
  end

  assign slot_ok   = (slot_q != '0) && (slot_q <= SLOT_W'(NUM_LISTS));
  assign cmd_ok    = (cmd_q <= CMD_READ);
  assign idx       = LIST_W'(slot_q - SLOT_W'(1));
  assign alloc_cur = slot_ok ? allocated[idx] : 1'b0;
  assign cap_cur   = slot_ok ? cap_arr[idx] : '0;
  assign fill_cur  = slot_ok ? fill_arr[idx] : '0;
  assign base      = ADDR_W'(idx) * ADDR_W'(CAPACITY);

  assign amt_ext  = SUM_W'(amount_q);
  assign cap_ext  = $signed(SUM_W'(cap_cur));
  assign new_size = cap_ext + amt_ext;
  assign new_cnt  = CNT_W'(new_size);

  always_comb begin
    single_st = ST_OK;
    if (!cmd_ok || !slot_ok) begin
      single_st = ST_BAD_POS;
    end else if (cmd_q == CMD_CREATE) begin
      if (alloc_cur) begin
        single_st = ST_EXISTS;
      end else if (amt_ext < SIZE_MIN) begin
        single_st = ST_BAD_SIZE;
      end else if (amt_ext > CAP_LIM) begin
        single_st = ST_NO_MEM;
      end
    end else if (!alloc_cur) begin
      single_st = ST_NO_LIST;
    end else begin
      case (cmd_q)
        CMD_APPEND: begin
          if (fill_cur >= cap_cur) begin
            single_st = ST_FULL;
          end
        end
        CMD_REMOVE_LAST, CMD_REMOVE_VALUE: begin
          if (fill_cur == '0) begin
            single_st = ST_EMPTY;
          end
        end
        CMD_RESIZE: begin
          if (new_size < SIZE_MIN) begin
            single_st = ST_BAD_NEW;
          end else if (new_size > CAP_LIM) begin
            single_st = ST_NO_MEM;
          end
        end
        default: begin
          single_st = ST_OK;
        end
      endcase
    end
  end

  assign single_ok = ctl.single && (single_st == ST_OK);

  always_comb begin
    alloc_we = 1'b0;
    cap_we   = 1'b0;
    fill_we  = 1'b0;
    cap_new  = cap_cur;
    fill_new = fill_cur;
    if (single_ok) begin
      case (cmd_q)
        CMD_CREATE: begin
          alloc_we = 1'b1;
          cap_we   = 1'b1;
          cap_new  = CNT_W'(amount_q);
          fill_we  = 1'b1;
          fill_new = '0;
        end
        CMD_APPEND: begin
          fill_we  = 1'b1;
          fill_new = fill_cur + CNT_W'(1);
        end
        CMD_REMOVE_LAST: begin
          fill_we  = 1'b1;
          fill_new = fill_cur - CNT_W'(1);
        end
        CMD_RESIZE: begin
          cap_we   = 1'b1;
          cap_new  = new_cnt;
          fill_we  = 1'b1;
          fill_new = (new_cnt < fill_cur) ? new_cnt : fill_cur;
        end
        default: begin
          fill_we = 1'b0;
        end
      endcase
    end else if (ctl.emit_hit) begin
      fill_we  = 1'b1;
      fill_new = fill_cur - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_LISTS; k++) begin
        allocated[k] <= 1'b0;
        cap_arr[k]   <= '0;
        fill_arr[k]  <= '0;
      end
    end else begin
      if (alloc_we) begin
        allocated[idx] <= 1'b1;
      end
      if (cap_we) begin
        cap_arr[idx] <= cap_new;
      end
      if (fill_we) begin
        fill_arr[idx] <= fill_new;
      end
    end
  end

  assign raddr  = base + ADDR_W'(idx_cnt);
  assign mem_we = (single_ok && (cmd_q == CMD_APPEND)) || ctl.shift_wr;
  assign waddr  = ctl.shift_wr ? (raddr - ADDR_W'(1)) : (base + ADDR_W'(fill_cur));
  assign wdata  = ctl.shift_wr ? rdata : value_q;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.clr_idx) begin
      idx_cnt <= '0;
    end else if (ctl.inc_idx) begin
      idx_cnt <= idx_cnt + IDX_W'(1);
    end
  end

  assign out_load = ctl.single || ctl.emit_hit || ctl.emit_miss || ctl.emit_elem;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (ctl.single) begin
        out_status <= single_st;
      end else if (ctl.emit_miss) begin
        out_status <= ST_NOT_FOUND;
      end else begin
        out_status <= ST_OK;
      end
      out_data     <= ctl.emit_elem ? rdata : '0;
      out_has_data <= ctl.emit_elem;
      out_last     <= ctl.emit_elem ? stat.last_idx : 1'b1;
    end
  end

  always_comb begin
    stat.go_search = cmd_ok && slot_ok && alloc_cur && (cmd_q == CMD_REMOVE_VALUE)
                     && (fill_cur != '0);
    stat.go_read   = cmd_ok && slot_ok && alloc_cur && (cmd_q == CMD_READ)
                     && (fill_cur != '0);
    stat.match     = (rdata == value_q);
    stat.last_idx  = (CNT_W'(idx_cnt) == (fill_cur - CNT_W'(1)));
    stat.out_free  = !out_valid || out_ready;
  end

  a_fill_within_cap: assert property (@(posedge clk) disable iff (rst)
    (slot_ok && alloc_cur) |-> (fill_cur <= cap_cur))
    else $error("list fill count exceeds its capacity");

  a_shift_not_first: assert property (@(posedge clk) disable iff (rst)
    ctl.shift_wr |-> (idx_cnt != '0))
    else $error("shift write at the first element of a list");

  a_append_has_room: assert property (@(posedge clk) disable iff (rst)
    (single_ok && (cmd_q == CMD_APPEND)) |-> (fill_cur < cap_cur))
    else $error("append accepted into a full list");

endmodule

`default_nettype wire

// File: rtl/mlt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mlt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mlt_pkg::mlt_stat_t stat,
  output mlt_pkg::mlt_cmd_t  ctl
);
  import mlt_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECODE    = 4'd1;
  localparam logic [3:0] S_SEEK_RD   = 4'd2;
  localparam logic [3:0] S_SEEK_CHK  = 4'd3;
  localparam logic [3:0] S_SHIFT_RD  = 4'd4;
  localparam logic [3:0] S_SHIFT_CHK = 4'd5;
  localparam logic [3:0] S_FIN_HIT   = 4'd6;
  localparam logic [3:0] S_FIN_MISS  = 4'd7;
  localparam logic [3:0] S_READ_RD   = 4'd8;
  localparam logic [3:0] S_READ_OUT  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.go_search) begin
          ctl.clr_idx = 1'b1;
          state_next  = S_SEEK_RD;
        end else if (stat.go_read) begin
          ctl.clr_idx = 1'b1;
          state_next  = S_READ_RD;
        end else if (stat.out_free) begin
          ctl.single = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SEEK_RD: begin
        state_next = S_SEEK_CHK;
      end
      S_SEEK_CHK: begin
        if (stat.last_idx) begin
          state_next = stat.match ? S_FIN_HIT : S_FIN_MISS;
        end else begin
          ctl.inc_idx = 1'b1;
          state_next  = stat.match ? S_SHIFT_RD : S_SEEK_RD;
        end
      end
      S_SHIFT_RD: begin
        state_next = S_SHIFT_CHK;
      end
      S_SHIFT_CHK: begin
        ctl.shift_wr = 1'b1;
        if (stat.last_idx) begin
          state_next = S_FIN_HIT;
        end else begin
          ctl.inc_idx = 1'b1;
          state_next  = S_SHIFT_RD;
        end
      end
      S_FIN_HIT: begin
        if (stat.out_free) begin
          ctl.emit_hit = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_FIN_MISS: begin
        if (stat.out_free) begin
          ctl.emit_miss = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_READ_RD: begin
        state_next = S_READ_OUT;
      end
      S_READ_OUT: begin
        if (stat.out_free) begin
          ctl.emit_elem = 1'b1;
          if (stat.last_idx) begin
            state_next = S_IDLE;
          end else begin
            ctl.inc_idx = 1'b1;
            state_next  = S_READ_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    (ctl.single || ctl.emit_hit || ctl.emit_miss || ctl.emit_elem) |-> stat.out_free)
    else $error("result written while the output register is still full");

  a_one_emit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.single, ctl.emit_hit, ctl.emit_miss, ctl.emit_elem}))
    else $error("more than one result source in a cycle");

  a_accept_then_decode: assert property (@(posedge clk) disable iff (rst)
    ctl.load_in |=> (state == S_DECODE))
    else $error("accepted word not followed by decode");

endmodule

`default_nettype wire

// File: rtl/multi_list_table_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Bank of NUM_LISTS bounded integer lists with up to CAPACITY elements each, driven by one
// command word at a time. Create, append, remove-last and resize register the command word
// and write their result from the decode state into the output register once it is free.
// Remove-value reads the list from the element memory one element at a time, through a
// read state and a check state, until it finds the value, then shifts the remaining
// elements down in the same way. A read gives one result word per element, each from the
// single registered read port of the element memory, once the output register is free. A
// new command is accepted once the previous one has put its last result into the output
// register, even if that result has not yet been taken. There is no clearing pass after
// reset: list contents are only ever read below a list's fill count.
module multi_list_table_engine #(
  parameter int NUM_LISTS = mlt_pkg::NUM_LISTS_DEF,
  parameter int CAPACITY  = mlt_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [mlt_pkg::S_TDATA_W-1:0]   s_tdata,  // slot, value, amount, zero pad
  input  logic [mlt_pkg::CMD_W-1:0]       s_tuser,  // cmd
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mlt_pkg::M_TDATA_W-1:0]   m_tdata,  // status, data, zero pad
  output logic                            m_tuser,  // has_data
  output logic                            m_tlast
);
  import mlt_pkg::*;

  mlt_cmd_t  ctl;
  mlt_stat_t stat;

  logic [SLOT_W-1:0]          in_slot;
  logic signed [VALUE_W-1:0]  in_value;
  logic signed [AMOUNT_W-1:0] in_amount;
  logic [STATUS_W-1:0]        out_status;
  logic signed [VALUE_W-1:0]  out_data;

  assign in_slot   = s_tdata[SLOT_W-1:0];
  assign in_value  = s_tdata[SLOT_W+VALUE_W-1:SLOT_W];
  assign in_amount = s_tdata[SLOT_W+VALUE_W+AMOUNT_W-1:SLOT_W+VALUE_W];

  mlt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .ctl      (ctl)
  );

  mlt_datapath #(
    .NUM_LISTS (NUM_LISTS),
    .CAPACITY  (CAPACITY)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .in_cmd       (s_tuser),
    .in_slot      (in_slot),
    .in_value     (in_value),
    .in_amount    (in_amount),
    .ctl          (ctl),
    .stat         (stat),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_status   (out_status),
    .out_data     (out_data),
    .out_has_data (m_tuser),
    .out_last     (m_tlast)
  );

  assign m_tdata = {{M_PAD_W{1'b0}}, out_data, out_status};

endmodule

`default_nettype wire
